[rtl/afftb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afftb_pkg
// Shared types, constants and the arctangent table for the 2D affine
// transform builder.
// ----------------------------------------------------------------------------
package afftb_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicW     = 34;   // Q2.30 with guard bits
  localparam int TrigW       = 17;   // Q1.15, +1.0 must be exact
  localparam int LinW        = 24;   // Q8.16
  localparam int CoordW      = 32;   // Q16.16
  localparam int ScaleW      = 16;   // Q8.8
  localparam int AngleW      = 16;
  localparam int StepIdxW    = $clog2(CordicSteps);

  localparam logic signed [CordicW-1:0] CordicX0 = 34'sd652032874;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
  } cordic_t;

  // data that rides alongside the rotation
  typedef struct packed {
    logic [1:0]               quad;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [ScaleW-1:0] scale_x;
    logic signed [ScaleW-1:0] scale_y;
    logic signed [CoordW-1:0] anchor_x;
    logic signed [CoordW-1:0] anchor_y;
  } side_t;

  typedef struct packed {
    logic signed [LinW-1:0] mxx;
    logic signed [LinW-1:0] mxy;
    logic signed [LinW-1:0] myx;
    logic signed [LinW-1:0] myy;
  } lin_t;

  function automatic logic signed [CordicW-1:0] atan_val(input logic [StepIdxW-1:0] idx);
    logic signed [CordicW-1:0] v;
    case (idx)
      4'd0:    v = 34'sd536870912;
      4'd1:    v = 34'sd316933406;
      4'd2:    v = 34'sd167458907;
      4'd3:    v = 34'sd85004756;
      4'd4:    v = 34'sd42667331;
      4'd5:    v = 34'sd21354465;
      4'd6:    v = 34'sd10679838;
      4'd7:    v = 34'sd5340245;
      4'd8:    v = 34'sd2670163;
      4'd9:    v = 34'sd1335087;
      4'd10:   v = 34'sd667544;
      4'd11:   v = 34'sd333772;
      4'd12:   v = 34'sd166886;
      4'd13:   v = 34'sd83443;
      4'd14:   v = 34'sd41722;
      4'd15:   v = 34'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/afftb_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afftb_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered. Cells are chained;
// each hands its vector, residual angle and sideband to the next every cycle.
// ----------------------------------------------------------------------------
module afftb_cordic_cell (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire  [afftb_pkg::StepIdxW-1:0]         step_idx,
  input  wire                                    vld_in,
  input  wire  afftb_pkg::cordic_t               vec_in,
  input  wire  afftb_pkg::side_t                 side_in,
  output logic                                   vld_out,
  output afftb_pkg::cordic_t                     vec_out,
  output afftb_pkg::side_t                       side_out
);
  import afftb_pkg::*;

  logic                       vld_r;
  cordic_t                    vec_r, vec_nxt;
  side_t                      side_r;
  logic signed [CordicW-1:0]  dx, dy, ang;

  always_comb begin
    dx  = vec_in.x >>> step_idx;
    dy  = vec_in.y >>> step_idx;
    ang = atan_val(step_idx);
    if (!vec_in.z[CordicW-1]) begin
      vec_nxt.x = vec_in.x - dy;
      vec_nxt.y = vec_in.y + dx;
      vec_nxt.z = vec_in.z - ang;
    end else begin
      vec_nxt.x = vec_in.x + dy;
      vec_nxt.y = vec_in.y - dx;
      vec_nxt.z = vec_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    vec_r  <= vec_nxt;
    side_r <= side_in;
  end

  assign vld_out  = vld_r;
  assign vec_out  = vec_r;
  assign side_out = side_r;

endmodule

`default_nettype wire

[rtl/afftb_lin.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afftb_lin
// Rounds the CORDIC vector to Q1.15, folds in the quadrant, then forms the
// four scaled linear entries with rounding and saturation. Three stages.
// ----------------------------------------------------------------------------
module afftb_lin (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  vld_in,
  input  wire  afftb_pkg::cordic_t vec_in,
  input  wire  afftb_pkg::side_t   side_in,
  output logic                 vld_out,
  output afftb_pkg::lin_t      lin_out,
  output afftb_pkg::side_t     side_out
);
  import afftb_pkg::*;

  localparam logic signed [CordicW-1:0] QHalf   = 34'sd16384;
  localparam logic signed [CordicW-1:0] QMax    = 34'sd32768;
  localparam logic signed [CordicW-1:0] QMin    = -34'sd32768;
  localparam logic signed [33:0]        LinRnd  = 34'sd64;
  localparam logic signed [33:0]        LinMax  = 34'sd8388607;
  localparam logic signed [33:0]        LinMin  = -34'sd8388608;

  function automatic logic signed [TrigW-1:0] to_q15(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] t;
    t = (v + QHalf) >>> 15;
    if (t > QMax)      return QMax[TrigW-1:0];
    else if (t < QMin) return QMin[TrigW-1:0];
    else               return t[TrigW-1:0];
  endfunction

  function automatic logic signed [LinW-1:0] lin_sat(input logic signed [33:0] p);
    logic signed [33:0] t;
    t = (p + LinRnd) >>> 7;
    if (t > LinMax)      return LinMax[LinW-1:0];
    else if (t < LinMin) return LinMin[LinW-1:0];
    else                 return t[LinW-1:0];
  endfunction

  // stage 1: trig values
  logic                      v1_r;
  logic signed [TrigW-1:0]   cos_r, sin_r, cos_nxt, sin_nxt;
  logic signed [TrigW-1:0]   c_q, s_q;
  side_t                     side1_r;
  // stage 2: raw products
  logic                      v2_r;
  logic signed [33:0]        pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [TrigW:0]     nsin;
  side_t                     side2_r;
  // stage 3: rounded entries
  logic                      v3_r;
  lin_t                      lin_r, lin_nxt;
  side_t                     side3_r;

  always_comb begin
    c_q = to_q15(vec_in.x);
    s_q = to_q15(vec_in.y);
    case (side_in.quad)
      2'd0:    begin cos_nxt = c_q;  sin_nxt = s_q;  end
      2'd1:    begin cos_nxt = -s_q; sin_nxt = c_q;  end
      2'd2:    begin cos_nxt = -c_q; sin_nxt = -s_q; end
      2'd3:    begin cos_nxt = s_q;  sin_nxt = -c_q; end
      default: begin cos_nxt = c_q;  sin_nxt = s_q;  end
    endcase
  end

  assign nsin = -{sin_r[TrigW-1], sin_r};

  always_comb begin
    lin_nxt.mxx = lin_sat(pxx_r);
    lin_nxt.mxy = lin_sat(pxy_r);
    lin_nxt.myx = lin_sat(pyx_r);
    lin_nxt.myy = lin_sat(pyy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    cos_r   <= cos_nxt;
    sin_r   <= sin_nxt;
    side1_r <= side_in;
    pxx_r   <= 34'(side1_r.scale_x) * 34'(cos_r);
    pxy_r   <= 34'(side1_r.scale_x) * 34'(sin_r);
    pyx_r   <= 34'(side1_r.scale_y) * 34'(nsin);
    pyy_r   <= 34'(side1_r.scale_y) * 34'(cos_r);
    side2_r <= side1_r;
    lin_r   <= lin_nxt;
    side3_r <= side2_r;
  end

  assign vld_out  = v3_r;
  assign lin_out  = lin_r;
  assign side_out = side3_r;

  property p_trig_range;
    @(posedge clk) disable iff (!rst_n)
      v1_r |-> (cos_r <= 17'sd32768 || cos_r == -17'sd32768) && cos_r >= -17'sd32768;
  endproperty
  a_trig_range: assert property (p_trig_range) else $error("cos out of unit range");

endmodule

`default_nettype wire

[rtl/afftb_trans.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afftb_trans
// Translation = position minus the anchor passed through the linear entries.
// Products, rounded sum, then subtract and saturate. Three stages.
// ----------------------------------------------------------------------------
module afftb_trans (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            vld_in,
  input  wire  afftb_pkg::lin_t          lin_in,
  input  wire  afftb_pkg::side_t         side_in,
  output logic                           vld_out,
  output afftb_pkg::lin_t                lin_out,
  output logic signed [afftb_pkg::CoordW-1:0] trans_x,
  output logic signed [afftb_pkg::CoordW-1:0] trans_y
);
  import afftb_pkg::*;

  localparam int ProdW = CoordW + LinW;   // 56
  localparam int SumW  = ProdW + 1;       // 57
  localparam int RndW  = SumW - 16;       // 41
  localparam int DiffW = RndW + 1;        // 42

  localparam logic signed [SumW-1:0]  SumRnd = 57'sd32768;
  localparam logic signed [DiffW-1:0] TMax   = 42'sd2147483647;
  localparam logic signed [DiffW-1:0] TMin   = -42'sd2147483648;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [DiffW-1:0] v);
    if (v > TMax)      return TMax[CoordW-1:0];
    else if (v < TMin) return TMin[CoordW-1:0];
    else               return v[CoordW-1:0];
  endfunction

  // stage 4
  logic                      v4_r;
  logic signed [ProdW-1:0]   pa_x_r, pb_x_r, pa_y_r, pb_y_r;
  lin_t                      lin4_r;
  logic signed [CoordW-1:0]  px4_r, py4_r;
  // stage 5
  logic                      v5_r;
  logic signed [SumW-1:0]    sx_full, sy_full;
  logic signed [RndW-1:0]    rx_r, ry_r;
  lin_t                      lin5_r;
  logic signed [CoordW-1:0]  px5_r, py5_r;
  // stage 6
  logic                      v6_r;
  logic signed [DiffW-1:0]   dx, dy;
  lin_t                      lin6_r;
  logic signed [CoordW-1:0]  tx_r, ty_r;

  always_comb begin
    sx_full = (SumW'(pa_x_r) + SumW'(pb_x_r) + SumRnd) >>> 16;
    sy_full = (SumW'(pa_y_r) + SumW'(pb_y_r) + SumRnd) >>> 16;
    dx = DiffW'(px5_r) - DiffW'(rx_r);
    dy = DiffW'(py5_r) - DiffW'(ry_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= vld_in;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    pa_x_r <= ProdW'(side_in.anchor_x) * ProdW'(lin_in.mxx);
    pb_x_r <= ProdW'(side_in.anchor_y) * ProdW'(lin_in.myx);
    pa_y_r <= ProdW'(side_in.anchor_x) * ProdW'(lin_in.mxy);
    pb_y_r <= ProdW'(side_in.anchor_y) * ProdW'(lin_in.myy);
    lin4_r <= lin_in;
    px4_r  <= side_in.pos_x;
    py4_r  <= side_in.pos_y;
    rx_r   <= sx_full[RndW-1:0];
    ry_r   <= sy_full[RndW-1:0];
    lin5_r <= lin4_r;
    px5_r  <= px4_r;
    py5_r  <= py4_r;
    tx_r   <= sat32(dx);
    ty_r   <= sat32(dy);
    lin6_r <= lin5_r;
  end

  assign vld_out = v6_r;
  assign lin_out = lin6_r;
  assign trans_x = tx_r;
  assign trans_y = ty_r;

endmodule

`default_nettype wire

[rtl/affine_2d_transform_builder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_2d_transform_builder_unit
// Builds the linear entries and translation of a 2D affine matrix from
// position, binary angle, per-axis scale and anchor, one item per cycle.
//
//   channel   handshake          payload
//   input     start / busy       in_pos_x/y, in_angle, in_scale_x/y, in_anchor_x/y
//   result    out_valid strobe   out_m_xx/xy/yx/yy, out_trans_x/y
//
// An item is taken on any cycle start is high; busy is always low.
// The pipeline is 16 CORDIC cells, 3 linear stages and 3 translation stages.
// Each result shows for one cycle with out_valid; the receiver cannot stall.
// Reset clears the valid flags only; items in flight are dropped.
// ----------------------------------------------------------------------------
module affine_2d_transform_builder_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  signed [afftb_pkg::CoordW-1:0]  in_pos_x,
  input  wire  signed [afftb_pkg::CoordW-1:0]  in_pos_y,
  input  wire         [afftb_pkg::AngleW-1:0]  in_angle,
  input  wire  signed [afftb_pkg::ScaleW-1:0]  in_scale_x,
  input  wire  signed [afftb_pkg::ScaleW-1:0]  in_scale_y,
  input  wire  signed [afftb_pkg::CoordW-1:0]  in_anchor_x,
  input  wire  signed [afftb_pkg::CoordW-1:0]  in_anchor_y,
  output logic                                 out_valid,
  output logic signed [afftb_pkg::LinW-1:0]    out_m_xx,
  output logic signed [afftb_pkg::LinW-1:0]    out_m_xy,
  output logic signed [afftb_pkg::LinW-1:0]    out_m_yx,
  output logic signed [afftb_pkg::LinW-1:0]    out_m_yy,
  output logic signed [afftb_pkg::CoordW-1:0]  out_trans_x,
  output logic signed [afftb_pkg::CoordW-1:0]  out_trans_y
);
  import afftb_pkg::*;

  localparam int Latency = CordicSteps + 6;

  logic [AngleW-1:0]  ang_bias;
  logic [1:0]         quad;
  logic [AngleW-1:0]  resid;
  cordic_t            vec0;
  side_t              side0;

  logic               vld_c  [CordicSteps+1];
  cordic_t            vec_c  [CordicSteps+1];
  side_t              side_c [CordicSteps+1];

  logic               lin_vld;
  lin_t               lin_m;
  side_t              lin_side;
  lin_t               fin_m;

  // split the turn into a quadrant and a residual centered on zero
  always_comb begin
    ang_bias       = in_angle + 16'h2000;
    quad           = ang_bias[AngleW-1:AngleW-2];
    resid          = in_angle - {quad, {(AngleW-2){1'b0}}};
    vec0.x         = CordicX0;
    vec0.y         = '0;
    vec0.z         = {{(CordicW-AngleW-16){resid[AngleW-1]}}, resid, 16'h0000};
    side0.quad     = quad;
    side0.pos_x    = in_pos_x;
    side0.pos_y    = in_pos_y;
    side0.scale_x  = in_scale_x;
    side0.scale_y  = in_scale_y;
    side0.anchor_x = in_anchor_x;
    side0.anchor_y = in_anchor_y;
  end

  assign busy      = 1'b0;
  assign vld_c[0]  = start;
  assign vec_c[0]  = vec0;
  assign side_c[0] = side0;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    afftb_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (StepIdxW'(g)),
      .vld_in   (vld_c[g]),
      .vec_in   (vec_c[g]),
      .side_in  (side_c[g]),
      .vld_out  (vld_c[g+1]),
      .vec_out  (vec_c[g+1]),
      .side_out (side_c[g+1])
    );
  end

  afftb_lin u_lin (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (vld_c[CordicSteps]),
    .vec_in   (vec_c[CordicSteps]),
    .side_in  (side_c[CordicSteps]),
    .vld_out  (lin_vld),
    .lin_out  (lin_m),
    .side_out (lin_side)
  );

  afftb_trans u_trans (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (lin_vld),
    .lin_in  (lin_m),
    .side_in (lin_side),
    .vld_out (out_valid),
    .lin_out (fin_m),
    .trans_x (out_trans_x),
    .trans_y (out_trans_y)
  );

  assign out_m_xx = fin_m.mxx;
  assign out_m_xy = fin_m.mxy;
  assign out_m_yx = fin_m.myx;
  assign out_m_yy = fin_m.myy;

  property p_item_out;
    @(posedge clk) disable iff (!rst_n) start |-> ##Latency out_valid;
  endproperty
  a_item_out: assert property (p_item_out) else $error("item lost in pipeline");

  property p_no_spurious;
    @(posedge clk) disable iff (!rst_n) out_valid |-> $past(start, Latency);
  endproperty
  a_no_spurious: assert property (p_no_spurious) else $error("result without item");

  property p_cordic_flow;
    @(posedge clk) disable iff (!rst_n)
      vld_c[CordicSteps] |-> $past(start, CordicSteps);
  endproperty
  a_cordic_flow: assert property (p_cordic_flow) else $error("CORDIC chain valid slip");

endmodule

`default_nettype wire
